>>> rtl/core/mvsm_pkg.sv
// mvsm_pkg: shared types and constants for the voice mixer
// no dependencies
package mvsm_pkg;

  localparam int unsigned SlotsDef       = 16;
  localparam int unsigned SampleWordsDef = 65536;

  typedef enum logic [2:0] {
    OP_WRITE = 3'd0,
    OP_START = 3'd1,
    OP_STOP  = 3'd2,
    OP_STOPALL = 3'd3,
    OP_TICK  = 3'd4
  } opcode_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADV,
    ST_RD0,
    ST_RD1,
    ST_ACC,
    ST_DONE
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic do_write;
    logic do_start;
    logic do_stop;
    logic do_stopall;
    logic clr_sum;
    logic advance;
    logic rd_first;
    logic rd_second;
    logic accumulate;
    logic next_slot;
    logic emit;
    logic emit_frame;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic slot_live;
    logic slot_last;
    logic two_reads;
  } stat_t;

endpackage

>>> rtl/core/mvsm_ctrl.sv
// mvsm_ctrl: sequencer for item decode and the per-voice tick walk
// depends on mvsm_pkg
module mvsm_ctrl import mvsm_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  input  logic [2:0]  opcode_i,
  input  stat_t       stat_i,
  output logic        busy,
  output cmd_t        cmd_o
);

  state_e state_q, state_d;
  logic   tick_q, tick_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      tick_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      tick_q  <= tick_d;
    end
  end

  always_comb begin
    state_d = state_q;
    tick_d  = tick_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          tick_d  = (opcode_i == OP_TICK);
          state_d = (opcode_i == OP_TICK) ? ST_ADV : ST_DONE;
        end
      end
      ST_ADV: state_d = stat_i.slot_live ? ST_RD0 : (stat_i.slot_last ? ST_DONE : ST_ADV);
      ST_RD0: state_d = stat_i.two_reads ? ST_RD1 : ST_ACC;
      ST_RD1: state_d = ST_ACC;
      ST_ACC: state_d = stat_i.slot_last ? ST_DONE : ST_ADV;
      ST_DONE: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    busy  = (state_q != ST_IDLE);
    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          cmd_o.do_write   = (opcode_i == OP_WRITE);
          cmd_o.do_start   = (opcode_i == OP_START);
          cmd_o.do_stop    = (opcode_i == OP_STOP);
          cmd_o.do_stopall = (opcode_i == OP_STOPALL);
          cmd_o.clr_sum    = 1'b1;
        end
      end
      ST_ADV: begin
        cmd_o.advance   = 1'b1;
        cmd_o.next_slot = !stat_i.slot_live;
      end
      ST_RD0: cmd_o.rd_first  = 1'b1;
      ST_RD1: cmd_o.rd_second = 1'b1;
      ST_ACC: begin
        cmd_o.accumulate = 1'b1;
        cmd_o.next_slot  = 1'b1;
      end
      ST_DONE: begin
        cmd_o.emit       = 1'b1;
        cmd_o.emit_frame = tick_q;
      end
      default: ;
    endcase
  end

endmodule

>>> rtl/core/mvsm_dp.sv
// mvsm_dp: voice table, sample memory, mix accumulators and result registers
// depends on mvsm_pkg
module mvsm_dp import mvsm_pkg::*; #(
  parameter int unsigned SLOTS        = SlotsDef,
  parameter int unsigned SAMPLE_WORDS = SampleWordsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cmd_t        cmd_i,
  input  logic [15:0] address_i,
  input  logic [15:0] word_data_i,
  input  logic [16:0] frame_count_i,
  input  logic [17:0] rate_step_i,
  input  logic        stereo_i,
  input  logic        eight_bit_i,
  input  logic        loop_enable_i,
  input  logic [15:0] voice_tag_i,
  output stat_t       stat_o,
  output logic signed [15:0] left_out_o,
  output logic signed [15:0] right_out_o,
  output logic        frame_valid_o,
  output logic        start_accepted_o,
  output logic        result_strobe_o
);

  localparam int unsigned SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned AW = $clog2(SAMPLE_WORDS);
  localparam int unsigned AccW = 16 + SW + 2;

  logic [SLOTS-1:0] active_q;
  logic [SLOTS-1:0] repeat_q, stereo_q, byte_q;
  logic [15:0] ident_q [SLOTS];
  logic [15:0] base_q  [SLOTS];
  logic [16:0] len_q   [SLOTS];
  logic [17:0] step_q  [SLOTS];
  logic [17:0] pos_q   [SLOTS];
  logic [15:0] frac_q  [SLOTS];

  logic [15:0] mem [SAMPLE_WORDS];
  logic [15:0] rd_q;

  logic [SW-1:0] slot_q;
  logic [17:0]   play_q;
  logic signed [AccW-1:0] suml_q, sumr_q;
  logic signed [16:0] vl_q;
  logic signed [15:0] lo_q, ro_q;
  logic fv_q, acc_q, stb_q;

  function automatic logic signed [15:0] sat(input logic signed [AccW-1:0] v);
    if (v > AccW'(32767))       sat = 16'sd32767;
    else if (v < -AccW'(32768)) sat = -16'sd32768;
    else                        sat = v[15:0];
  endfunction

  // free slot search (priority)
  logic [SLOTS-1:0] free_oh;
  logic [SW-1:0]    free_idx;
  logic             any_free;
  always_comb begin
    free_idx = '0;
    any_free = 1'b0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!active_q[i]) begin
        free_idx = SW'(i);
        any_free = 1'b1;
      end
    end
    free_oh = '0;
    if (any_free) free_oh[free_idx] = 1'b1;
  end

  // position advance for the current slot
  logic [16:0] fsum;
  logic [17:0] pnext;
  logic        at_end, cur_live;
  assign fsum     = {1'b0, frac_q[slot_q]} + {1'b0, step_q[slot_q][15:0]};
  assign pnext    = pos_q[slot_q] + {16'd0, step_q[slot_q][17:16]} + {17'd0, fsum[16]};
  assign at_end   = ({1'b0, pnext} >= {2'b0, len_q[slot_q]});
  assign cur_live = active_q[slot_q] && (!at_end || repeat_q[slot_q]);

  assign stat_o.slot_live = cmd_i.advance && cur_live;
  assign stat_o.slot_last = (slot_q == SW'(SLOTS - 1));
  assign stat_o.two_reads = stereo_q[slot_q] && !byte_q[slot_q];

  // read address: byte mode reads one word covering both bytes of a stereo frame
  logic [18:0] woff;
  logic [AW-1:0] raddr;
  always_comb begin
    if (byte_q[slot_q]) woff = stereo_q[slot_q] ? {1'b0, play_q} : {2'b0, play_q[17:1]};
    else                woff = stereo_q[slot_q] ? {play_q, cmd_i.rd_second} : {1'b0, play_q};
    raddr = AW'({4'b0, base_q[slot_q]} + {1'b0, woff});
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.do_write) mem[AW'(address_i)] <= word_data_i;
    rd_q <= mem[raddr];
  end

  // decode of the word read
  logic signed [16:0] bl, bh, sv;
  assign bl = {1'b0, rd_q[7:0], 8'd0} - 17'sd32768;
  assign bh = {1'b0, rd_q[15:8], 8'd0} - 17'sd32768;
  assign sv = {rd_q[15], rd_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= '0;
      slot_q   <= '0;
      stb_q    <= 1'b0;
    end else begin
      stb_q <= cmd_i.emit;
      if (cmd_i.do_start && any_free) active_q <= active_q | free_oh;
      if (cmd_i.do_stopall) active_q <= '0;
      if (cmd_i.do_stop)
        for (int i = 0; i < SLOTS; i++)
          if (ident_q[i] == voice_tag_i) active_q[i] <= 1'b0;
      if (cmd_i.advance && active_q[slot_q] && at_end && !repeat_q[slot_q])
        active_q[slot_q] <= 1'b0;
      if (cmd_i.clr_sum) slot_q <= '0;
      else if (cmd_i.next_slot) slot_q <= stat_o.slot_last ? '0 : slot_q + SW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.do_start && any_free) begin
      repeat_q[free_idx] <= loop_enable_i;
      stereo_q[free_idx] <= stereo_i;
      byte_q[free_idx]   <= eight_bit_i;
      ident_q[free_idx]  <= voice_tag_i;
      base_q[free_idx]   <= address_i;
      len_q[free_idx]    <= frame_count_i;
      step_q[free_idx]   <= rate_step_i;
      pos_q[free_idx]    <= '0;
      frac_q[free_idx]   <= '0;
    end
    if (cmd_i.advance && active_q[slot_q]) begin
      pos_q[slot_q]  <= at_end ? '0 : pnext;
      frac_q[slot_q] <= at_end ? '0 : fsum[15:0];
      play_q         <= at_end ? '0 : pnext;
    end
    if (cmd_i.clr_sum) begin
      suml_q <= '0;
      sumr_q <= '0;
      acc_q  <= cmd_i.do_start && any_free;
    end
    if (cmd_i.rd_first) begin
      // first read lands next cycle; captured in rd_second or accumulate
    end
    if (cmd_i.rd_second) vl_q <= sv;
    if (cmd_i.accumulate) begin
      if (!stereo_q[slot_q]) begin
        suml_q <= suml_q + AccW'(byte_q[slot_q] ? (play_q[0] ? bh : bl) : sv);
        sumr_q <= sumr_q + AccW'(byte_q[slot_q] ? (play_q[0] ? bh : bl) : sv);
      end else if (byte_q[slot_q]) begin
        suml_q <= suml_q + AccW'(bl);
        sumr_q <= sumr_q + AccW'(bh);
      end else begin
        suml_q <= suml_q + AccW'(vl_q);
        sumr_q <= sumr_q + AccW'(sv);
      end
    end
    if (cmd_i.emit) begin
      fv_q <= cmd_i.emit_frame;
      lo_q <= cmd_i.emit_frame ? sat(suml_q) : '0;
      ro_q <= cmd_i.emit_frame ? sat(sumr_q) : '0;
    end
  end

  assign left_out_o       = lo_q;
  assign right_out_o      = ro_q;
  assign frame_valid_o    = fv_q;
  assign start_accepted_o = acc_q && !fv_q;
  assign result_strobe_o  = stb_q;

endmodule

>>> rtl/core/multi_voice_sample_mixer.sv
// multi_voice_sample_mixer: top level of the pcm voice mixer
// depends on mvsm_pkg, mvsm_ctrl, mvsm_dp
//
// channel   direction  handshake
// command   in         start & !busy, fields opcode_i .. voice_tag_i
// result    out        result_strobe_o for one cycle, no back-pressure
//
// write, start and stop items pass through the done state before the registered strobe
// a tick walks every voice: an idle slot takes only the advance state, a live voice adds
// the read and accumulate states (a second read when 16-bit stereo needs two sample
// memory reads), then the done state; the single read port of the sample memory sets the per-voice cost
// reset clears the active flags and the sequencer; the receiver cannot stall results
module multi_voice_sample_mixer import mvsm_pkg::*; #(
  parameter int unsigned SLOTS        = SlotsDef,
  parameter int unsigned SAMPLE_WORDS = SampleWordsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  opcode_i,
  input  logic [15:0] address_i,
  input  logic [15:0] word_data_i,
  input  logic [16:0] frame_count_i,
  input  logic [17:0] rate_step_i,
  input  logic        stereo_i,
  input  logic        eight_bit_i,
  input  logic        loop_enable_i,
  input  logic [15:0] voice_tag_i,
  output logic signed [15:0] left_out_o,
  output logic signed [15:0] right_out_o,
  output logic        frame_valid_o,
  output logic        start_accepted_o,
  output logic        result_strobe_o
);

  cmd_t  cmd;
  stat_t stat;

  mvsm_ctrl u_ctrl (
    .clk_i, .rst_ni, .start, .opcode_i, .stat_i(stat),
    .busy, .cmd_o(cmd)
  );

  mvsm_dp #(.SLOTS(SLOTS), .SAMPLE_WORDS(SAMPLE_WORDS)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .address_i, .word_data_i, .frame_count_i,
    .rate_step_i, .stereo_i, .eight_bit_i, .loop_enable_i, .voice_tag_i,
    .stat_o(stat), .left_out_o, .right_out_o, .frame_valid_o,
    .start_accepted_o, .result_strobe_o
  );

  // a result always follows work: busy was high just before the strobe
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_strobe_o |-> $past(busy)) else $error("strobe without work");
  // a frame never claims a start
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_strobe_o |-> !(frame_valid_o && start_accepted_o)) else $error("mixed flags");
  // non-frame results carry silence
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_strobe_o && !frame_valid_o) |-> (left_out_o == 0 && right_out_o == 0))
    else $error("nonzero mix");

endmodule

>>> tb/mvsm_checker.sv
// mvsm_checker: watches the command and result channels of the voice mixer,
// predicts every result and compares it; depends on mvsm_pkg
module mvsm_checker import mvsm_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic        busy_i,
  input  logic [2:0]  opcode_i,
  input  logic [15:0] address_i,
  input  logic [15:0] word_data_i,
  input  logic [16:0] frame_count_i,
  input  logic [17:0] rate_step_i,
  input  logic        stereo_i,
  input  logic        eight_bit_i,
  input  logic        loop_enable_i,
  input  logic [15:0] voice_tag_i,
  input  logic signed [15:0] left_out_i,
  input  logic signed [15:0] right_out_i,
  input  logic        frame_valid_i,
  input  logic        start_accepted_i,
  input  logic        result_strobe_i,
  output int          fail_count_o,
  output int          pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int Voices = SlotsDef;

  typedef struct packed {
    logic signed [15:0] left;
    logic signed [15:0] right;
    logic               frame;
    logic               granted;
  } mix_result_t;

  logic        v_on     [Voices];
  logic        v_loop   [Voices];
  logic        v_stereo [Voices];
  logic        v_byte   [Voices];
  logic [15:0] v_tag    [Voices];
  logic [15:0] v_base   [Voices];
  logic [16:0] v_len    [Voices];
  logic [17:0] v_step   [Voices];
  logic [17:0] v_pos    [Voices];
  logic [15:0] v_frac   [Voices];
  logic [15:0] sample_mem [SampleWordsDef];

  mix_result_t expected_mix_q[$];
  int          fail_count;

  assign fail_count_o = fail_count;
  assign pending_o    = expected_mix_q.size();

  task automatic report_mismatch(input string what);
    fail_count++;
    $display("%0t mismatch: %s", $realtime, what);
  endtask

  function automatic int word_value(input logic [15:0] base, input int unsigned ofs);
    logic [15:0] a;
    a = base + ofs[15:0];
    return int'($signed(sample_mem[a]));
  endfunction

  function automatic int byte_value(input logic [15:0] base, input int unsigned n);
    logic [15:0] a;
    logic [15:0] w;
    a = base + n[16:1];
    w = sample_mem[a];
    return (n[0] ? int'(w[15:8]) : int'(w[7:0])) * 256 - 32768;
  endfunction

  function automatic logic signed [15:0] clip16(input int v);
    if (v < -32768) return 16'sh8000;
    if (v > 32767) return 16'sh7fff;
    return v[15:0];
  endfunction

  // update the voice state for one transfer and return what it must produce
  function automatic mix_result_t mix_next(input opcode_e op);
    mix_result_t r;
    int          sum_l;
    int          sum_r;
    int unsigned f;
    int unsigned p;
    int          v;
    r = '0;
    sum_l = 0;
    sum_r = 0;
    case (op)
      OP_WRITE: sample_mem[address_i] = word_data_i;
      OP_START: begin
        for (int s = 0; s < Voices; s++) begin
          if (!v_on[s]) begin
            v_on[s] = 1'b1;      v_loop[s] = loop_enable_i;
            v_stereo[s] = stereo_i; v_byte[s] = eight_bit_i;
            v_tag[s] = voice_tag_i; v_base[s] = address_i;
            v_len[s] = frame_count_i; v_step[s] = rate_step_i;
            v_pos[s] = '0;       v_frac[s] = '0;
            r.granted = 1'b1;
            break;
          end
        end
      end
      // stop by id also hits inactive voices
      OP_STOP: for (int s = 0; s < Voices; s++) if (v_tag[s] == voice_tag_i) v_on[s] = 1'b0;
      OP_STOPALL: for (int s = 0; s < Voices; s++) v_on[s] = 1'b0;
      OP_TICK: begin
        r.frame = 1'b1;
        for (int s = 0; s < Voices; s++) begin
          if (!v_on[s]) continue;
          f = v_frac[s] + v_step[s];
          p = (v_pos[s] + (f >> 16)) & 32'h3ffff;
          v_frac[s] = f[15:0];
          v_pos[s] = p[17:0];
          if (p >= v_len[s]) begin
            if (v_loop[s]) begin
              v_pos[s] = '0;
              v_frac[s] = '0;
              p = 0;
            end else begin
              v_on[s] = 1'b0;
              continue;
            end
          end
          if (!v_stereo[s]) begin
            v = v_byte[s] ? byte_value(v_base[s], p) : word_value(v_base[s], p);
            sum_l += v;
            sum_r += v;
          end else if (v_byte[s]) begin
            sum_l += byte_value(v_base[s], 2 * p);
            sum_r += byte_value(v_base[s], 2 * p + 1);
          end else begin
            sum_l += word_value(v_base[s], 2 * p);
            sum_r += word_value(v_base[s], 2 * p + 1);
          end
        end
        r.left = clip16(sum_l);
        r.right = clip16(sum_r);
      end
      default: ;  // reserved codes leave everything alone
    endcase
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    mix_result_t want;
    if (!rst_ni) begin
      for (int s = 0; s < Voices; s++) begin
        v_on[s] = 1'b0;
        v_tag[s] = '0;
      end
      expected_mix_q.delete();
      fail_count = 0;
    end else begin
      // command transfer: predict before the strobe check, results lag anyway
      if (start_i && !busy_i) expected_mix_q.push_back(mix_next(opcode_e'(opcode_i)));
      if (result_strobe_i) begin
        if (expected_mix_q.size() == 0) begin
          report_mismatch("result strobe with nothing expected");
        end else begin
          want = expected_mix_q.pop_front();
          if (left_out_i !== want.left)
            report_mismatch($sformatf("left_out %0d, expected %0d", left_out_i, want.left));
          if (right_out_i !== want.right)
            report_mismatch($sformatf("right_out %0d, expected %0d", right_out_i, want.right));
          if (frame_valid_i !== want.frame)
            report_mismatch($sformatf("frame_valid %b, expected %b", frame_valid_i, want.frame));
          if (start_accepted_i !== want.granted)
            report_mismatch($sformatf("start_accepted %b, expected %b",
                                      start_accepted_i, want.granted));
        end
      end
    end
  end

endmodule

>>> tb/tb_top.sv
// tb_top: stimulus and verdict for the multi-voice sample mixer
// depends on mvsm_pkg, multi_voice_sample_mixer and mvsm_checker
module tb_top import mvsm_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  // reserved opcode range, the block must answer with an all-zero result
  localparam int unsigned OpResvFirst = 5;
  localparam int unsigned OpResvLast  = 7;
  // sample memory window that is always written before any voice reads it;
  // it runs across the top of the address space so reads wrap to zero
  localparam logic [15:0] WindowBase = 16'hffc0;
  localparam int unsigned WindowWords = 256;
  localparam int unsigned IdleLimit = 5000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [2:0]  opcode_i = '0;
  logic [15:0] address_i = '0;
  logic [15:0] word_data_i = '0;
  logic [16:0] frame_count_i = '0;
  logic [17:0] rate_step_i = '0;
  logic        stereo_i = 1'b0;
  logic        eight_bit_i = 1'b0;
  logic        loop_enable_i = 1'b0;
  logic [15:0] voice_tag_i = '0;
  logic signed [15:0] left_out_o;
  logic signed [15:0] right_out_o;
  logic        frame_valid_o;
  logic        start_accepted_o;
  logic        result_strobe_o;
  int          fail_count;
  int          pending;
  int          sender_idle_pct = 0;
  int          quiet_cycles = 0;

  always #5 clk_i = ~clk_i;

  multi_voice_sample_mixer dut (.*);

  mvsm_checker u_checker (
    .clk_i, .rst_ni, .start_i(start), .busy_i(busy), .opcode_i, .address_i, .word_data_i,
    .frame_count_i, .rate_step_i, .stereo_i, .eight_bit_i, .loop_enable_i, .voice_tag_i,
    .left_out_i(left_out_o), .right_out_i(right_out_o), .frame_valid_i(frame_valid_o),
    .start_accepted_i(start_accepted_o), .result_strobe_i(result_strobe_o),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  // watchdog: cycles with neither a command transfer nor a result
  always @(posedge clk_i) begin
    if ((start && !busy) || result_strobe_o) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= IdleLimit) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // one command transfer; called and returns at a falling edge
  task automatic send_cmd(input logic [2:0] op, input logic [15:0] addr,
                          input logic [15:0] data, input logic [16:0] len,
                          input logic [17:0] step, input logic st, input logic b8,
                          input logic lp, input logic [15:0] tag);
    while ($urandom_range(99) < sender_idle_pct) begin
      start = 1'b0;
      @(negedge clk_i);
    end
    start = 1'b1;
    opcode_i = op; address_i = addr; word_data_i = data; frame_count_i = len;
    rate_step_i = step; stereo_i = st; eight_bit_i = b8; loop_enable_i = lp;
    voice_tag_i = tag;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // command with random filler in the fields the opcode does not use
  task automatic send_simple(input logic [2:0] op, input logic [15:0] tag);
    send_cmd(op, 16'($urandom), 16'($urandom), 17'($urandom), 18'($urandom),
             1'($urandom), 1'($urandom), 1'($urandom), tag);
  endtask

  task automatic write_word(input logic [15:0] addr, input logic [15:0] data);
    send_cmd(OP_WRITE, addr, data, 17'($urandom), 18'($urandom), 1'($urandom),
             1'($urandom), 1'($urandom), 16'($urandom));
  endtask

  // voice start whose every reachable frame lies inside the written window;
  // k is the word offset of the base inside the window
  task automatic start_voice(input int unsigned k, input logic st, input logic b8,
                             input logic lp, input logic [17:0] step,
                             input logic [15:0] tag, input bit long_len);
    int unsigned room;
    int unsigned max_len;
    logic [16:0] len;
    room = WindowWords - k;
    // frames that fit: words per frame is 1, 2, half or 1
    case ({st, b8})
      2'b00: max_len = room;
      2'b10: max_len = room / 2;
      2'b01: max_len = room * 2;
      default: max_len = room;
    endcase
    // a zero step never leaves frame zero, so any length is safe there
    if (step == 0 && long_len && max_len > 0) len = 17'($urandom);
    else len = 17'($urandom_range(max_len));
    send_cmd(OP_START, WindowBase + k[15:0], 16'($urandom), len, step, st, b8, lp, tag);
  endtask

  task automatic wait_drained();
    start = 1'b0;
    while (pending != 0) @(negedge clk_i);
    // a transfer may still be working when the queue empties
    repeat (80) @(negedge clk_i);
  endtask

  function automatic logic [17:0] pick_step();
    case ($urandom_range(9))
      0: return 18'd0;
      1: return 18'($urandom);                // full range, bits up to the top
      2: return 18'h3ffff;
      default: return 18'($urandom_range(18'h28000));
    endcase
  endfunction

  task automatic random_item();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 45) begin
      send_simple(OP_TICK, 16'($urandom));
    end else if (pick < 65) begin
      start_voice($urandom_range(WindowWords - 1), 1'($urandom), 1'($urandom), 1'($urandom),
                  pick_step(), 16'($urandom_range(7)), $urandom_range(3) == 0);
    end else if (pick < 75) begin
      // small tag pool so stops actually hit, plus the odd wide tag
      send_simple(OP_STOP, ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(7)));
    end else if (pick < 78) begin
      send_simple(OP_STOPALL, 16'($urandom));
    end else if (pick < 95) begin
      // anywhere in memory, window included, so voice data changes under play
      if ($urandom_range(1))
        write_word(WindowBase + 16'($urandom_range(WindowWords - 1)), 16'($urandom));
      else write_word(16'($urandom), 16'($urandom));
    end else begin
      send_simple(3'($urandom_range(OpResvLast, OpResvFirst)), 16'($urandom));
    end
  endtask

  initial begin
    int idle_phase[4] = '{0, 88, 9, 0};
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed part: silence, then fill the read window
    send_simple(OP_TICK, 16'h0);
    for (int unsigned i = 0; i < WindowWords; i++) begin
      logic [15:0] w;
      case (i)
        0: w = 16'h7fff;
        1: w = 16'h8000;
        2: w = 16'hffff;
        3: w = 16'h0000;
        default: w = 16'($urandom);
      endcase
      write_word(WindowBase + i[15:0], w);
    end
    // all voices on the max positive word, zero step, longest length
    for (int i = 0; i < 16; i++)
      send_cmd(OP_START, WindowBase, 16'h0, 17'h1ffff, 18'h0, 1'b0, 1'b0, 1'b0, 16'(i));
    // no free voice left
    send_cmd(OP_START, WindowBase, 16'hffff, 17'h1ffff, 18'h3ffff, 1'b1, 1'b1, 1'b1, 16'hffff);
    send_simple(OP_TICK, 16'h0);                 // saturates high
    send_simple(OP_STOP, 16'd3);
    send_simple(OP_STOP, 16'hffff);              // matches nothing
    send_simple(OP_TICK, 16'h0);
    send_simple(OP_STOPALL, 16'h0);
    // negative saturation of the left sum with 16-bit stereo on the words 8000 and ffff
    for (int i = 0; i < 3; i++)
      send_cmd(OP_START, WindowBase + 16'd1, 16'h0, 17'd1, 18'h0, 1'b1, 1'b0, 1'b1, 16'hbeef);
    // zero-length looping voice stays on frame zero, looping 8-bit voice wraps, max step non-looping
    send_cmd(OP_START, WindowBase + 16'd8, 16'h0, 17'd0, 18'h10000, 1'b0, 1'b0, 1'b1, 16'h1);
    send_cmd(OP_START, WindowBase + 16'd60, 16'h0, 17'd3, 18'h18000, 1'b1, 1'b1, 1'b1, 16'h2);
    send_cmd(OP_START, WindowBase + 16'd100, 16'h0, 17'd9, 18'h3ffff, 1'b0, 1'b1, 1'b0, 16'h3);
    repeat (4) send_simple(OP_TICK, 16'h0);
    for (int unsigned op = OpResvFirst; op <= OpResvLast; op++)
      send_simple(3'(op), 16'($urandom));
    send_simple(OP_STOPALL, 16'h0);
    wait_drained();

    // random part in phases of sender idling, draining between them
    foreach (idle_phase[ph]) begin
      sender_idle_pct = idle_phase[ph];
      for (int n = 0; n < 140; n++) random_item();
      wait_drained();
    end

    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
